[sv/dacc_pkg.sv]
package dacc_pkg;

  // Width of memory addresses and of the program counter.
  localparam int ADDR_W = 7;

  // Largest magnitude of a decodable or loadable word.
  localparam logic signed [31:0] WORD_MAX = 32'sd9999;
  localparam logic signed [31:0] WORD_MIN = -32'sd9999;

  // Instruction codes.
  localparam logic [6:0] OP_READ   = 7'd10;
  localparam logic [6:0] OP_WRITE  = 7'd11;
  localparam logic [6:0] OP_LOAD   = 7'd20;
  localparam logic [6:0] OP_STORE  = 7'd21;
  localparam logic [6:0] OP_ADD    = 7'd30;
  localparam logic [6:0] OP_SUB    = 7'd31;
  localparam logic [6:0] OP_DIV    = 7'd32;
  localparam logic [6:0] OP_MUL    = 7'd33;
  localparam logic [6:0] OP_BR     = 7'd40;
  localparam logic [6:0] OP_BRNEG  = 7'd41;
  localparam logic [6:0] OP_BRZERO = 7'd42;
  localparam logic [6:0] OP_HALT   = 7'd43;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_HALT = 3'd1,
    ST_END  = 3'd2,
    ST_DIVZ = 3'd3,
    ST_OVF  = 3'd4,
    ST_IGN  = 3'd5,
    ST_REJ  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_REJECT,
    KIND_STEP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  addr;
    logic signed [31:0] data;
  } item_t;

  // Queue side seen by the execution unit.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef struct packed {
    status_t            status;
    logic               printed;
    logic signed [31:0] pval;
    logic signed [31:0] fetched;
    logic signed [31:0] acc;
    logic [ADDR_W-1:0]  pc;
  } result_t;

endpackage

[sv/dacc_ram.sv]
module dacc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/dacc_front.sv]
module dacc_front
  import dacc_pkg::*;
#(
  parameter int MEM_WORDS = 100
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              req_type,
  input  logic [ADDR_W-1:0] load_address,
  input  logic signed [31:0] data_word,
  output queue_out_t        qout,
  input  logic              take
);

  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  item_t      entries [2];
  item_t      incoming;
  logic       do_push;
  logic       do_take;

  // Classify the item as it arrives so the back end only executes.
  always_comb begin
    incoming.addr = load_address;
    incoming.data = data_word;
    if (req_type) begin
      incoming.kind = KIND_STEP;
    end else if (load_address >= ADDR_W'(MEM_WORDS) || data_word > WORD_MAX ||
                 data_word < WORD_MIN) begin
      incoming.kind = KIND_REJECT;
    end else begin
      incoming.kind = KIND_LOAD;
    end
  end

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_take = take && (count != 2'd0);

  assign qout.valid = (count != 2'd0);
  assign qout.item  = entries[rd_ptr];

  // Two-entry queue between the front and the execution unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= incoming;
        wr_ptr          <= !wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_take);
    end
  end

endmodule

[sv/dacc_back.sv]
module dacc_back
  import dacc_pkg::*;
#(
  parameter int MEM_WORDS = 100
) (
  input  logic       clk,
  input  logic       rst,
  input  queue_out_t qin,
  output logic       take,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  localparam int RAM_AW = $clog2(MEM_WORDS);
  localparam logic [ADDR_W-1:0] PC_END = ADDR_W'(MEM_WORDS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_DEC,
    S_OPND,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  pc;
  logic               running;
  logic signed [31:0] acc;
  logic signed [31:0] cur_data;
  status_t            st;
  logic               printed;
  logic signed [31:0] pval;
  logic signed [31:0] fetched;
  logic               dec_ok;
  logic [26:0]        qprod;
  logic [6:0]         op;
  logic [ADDR_W-1:0]  opa;
  logic [ADDR_W-1:0]  nxt;
  logic               stop;
  logic [63:0]        prod;
  logic [31:0]        mcand;
  logic [31:0]        rem;
  logic [31:0]        qr;
  logic               neg;
  logic [4:0]         cnt;

  logic [MEM_WORDS-1:0] vbits;
  logic                 rvalid;
  logic                 we;
  logic [RAM_AW-1:0]    waddr;
  logic [31:0]          wdata;
  logic [RAM_AW-1:0]    raddr;
  logic [31:0]          rdata;
  logic signed [31:0]   rd_eff;

  logic [6:0]         quo;
  logic [13:0]        rem100;
  logic signed [32:0] add33;
  logic signed [32:0] sub33;
  logic [32:0]        mul_sum;
  logic [32:0]        div_t;
  logic [31:0]        abs_acc;
  logic [31:0]        abs_m;
  logic               div_go;

  dacc_ram #(
    .WIDTH(32),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Words never written read as zero.
  assign rd_eff = rvalid ? $signed(rdata) : 32'sd0;
  assign raddr  = (state == S_OPND) ? opa[RAM_AW-1:0] : pc[RAM_AW-1:0];

  // Memory writes: program loads from idle, READ and STORE from execute.
  always_comb begin
    we    = 1'b0;
    waddr = opa[RAM_AW-1:0];
    wdata = acc;
    if (state == S_IDLE && qin.valid && qin.item.kind == KIND_LOAD) begin
      we    = 1'b1;
      waddr = qin.item.addr[RAM_AW-1:0];
      wdata = qin.item.data;
    end else if (state == S_EXEC && dec_ok && op == OP_READ) begin
      we    = 1'b1;
      wdata = cur_data;
    end else if (state == S_EXEC && dec_ok && op == OP_STORE) begin
      we    = 1'b1;
    end
  end

  // Valid bits stand for the cleared memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (we) begin
      vbits[waddr] <= 1'b1;
    end
    rvalid <= vbits[raddr];
  end

  // Decimal split: quotient by reciprocal multiply, then remainder.
  assign quo    = qprod[25:19];
  assign rem100 = fetched[13:0] - 14'({7'd0, quo} * 14'd100);

  // Datapath for the operations done in the execute state and for the iterative ones.
  assign add33   = {acc[31], acc} + {rd_eff[31], rd_eff};
  assign sub33   = {acc[31], acc} - {rd_eff[31], rd_eff};
  assign abs_acc = acc[31] ? 32'(-acc) : acc;
  assign abs_m   = rd_eff[31] ? 32'(-rd_eff) : rd_eff;
  assign mul_sum = {1'b0, prod[63:32]} + (prod[0] ? {1'b0, mcand} : 33'd0);
  assign div_t   = {rem, qr[31]} - {1'b0, mcand};

  // A divide starts its iterations only when neither error case applies.
  assign div_go = dec_ok && op == OP_DIV && rd_eff != 32'sd0 &&
                  !(acc == 32'sh8000_0000 && rd_eff == -32'sd1);

  assign take      = (state == S_IDLE) && qin.valid;
  assign res_valid = (state == S_DONE);
  assign res.status  = st;
  assign res.printed = printed;
  assign res.pval    = pval;
  assign res.fetched = fetched;
  assign res.acc     = acc;
  assign res.pc      = pc;

  // Sequencer: one item at a time from the queue to the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pc      <= '0;
      running <= 1'b1;
      acc     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (qin.valid) begin
            cur_data <= qin.item.data;
            st       <= ST_OK;
            printed  <= 1'b0;
            pval     <= '0;
            fetched  <= '0;
            stop     <= 1'b0;
            case (qin.item.kind)
              KIND_LOAD: begin
                pc      <= '0;
                running <= 1'b1;
                state   <= S_DONE;
              end
              KIND_STEP: begin
                if (!running) begin
                  st    <= ST_IGN;
                  state <= S_DONE;
                end else if (pc >= PC_END) begin
                  pc      <= PC_END;
                  running <= 1'b0;
                  st      <= ST_END;
                  state   <= S_DONE;
                end else begin
                  state <= S_FETCH;
                end
              end
              default: begin
                st    <= ST_REJ;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FETCH: begin
          fetched <= rd_eff;
          dec_ok  <= !rd_eff[31] && (rd_eff <= WORD_MAX);
          qprod   <= 27'(rd_eff[13:0]) * 27'd5243;
          state   <= S_DEC;
        end
        S_DEC: begin
          op <= quo;
          if (rem100[6:0] < 7'(MEM_WORDS)) begin
            opa <= rem100[6:0];
          end else begin
            opa <= '0;
          end
          state <= S_OPND;
        end
        S_OPND: begin
          nxt   <= pc + 1'b1;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (dec_ok && op == OP_MUL) begin
            state <= S_MUL;
          end else if (div_go) begin
            state <= S_DIV;
          end else begin
            state <= S_FIN;
          end
          if (dec_ok) begin
            case (op)
              OP_WRITE: begin
                printed <= 1'b1;
                pval    <= rd_eff;
              end
              OP_LOAD: acc <= rd_eff;
              OP_ADD: begin
                if (add33[32] != add33[31]) begin
                  st   <= ST_OVF;
                  stop <= 1'b1;
                end else begin
                  acc <= add33[31:0];
                end
              end
              OP_SUB: begin
                if (sub33[32] != sub33[31]) begin
                  st   <= ST_OVF;
                  stop <= 1'b1;
                end else begin
                  acc <= sub33[31:0];
                end
              end
              OP_DIV: begin
                if (rd_eff == 32'sd0) begin
                  st   <= ST_DIVZ;
                  stop <= 1'b1;
                end else if (acc == 32'sh8000_0000 && rd_eff == -32'sd1) begin
                  st   <= ST_OVF;
                  stop <= 1'b1;
                end else begin
                  mcand <= abs_m;
                  qr    <= abs_acc;
                  rem   <= '0;
                  neg   <= acc[31] ^ rd_eff[31];
                  cnt   <= '0;
                end
              end
              OP_MUL: begin
                mcand <= abs_acc;
                prod  <= {32'd0, abs_m};
                neg   <= acc[31] ^ rd_eff[31];
                cnt   <= '0;
              end
              OP_BR: nxt <= opa;
              OP_BRNEG: begin
                if (acc[31]) begin
                  nxt <= opa;
                end
              end
              OP_BRZERO: begin
                if (acc == 32'sd0) begin
                  nxt <= opa;
                end
              end
              OP_HALT: begin
                st   <= ST_HALT;
                stop <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          // Shift-add, one multiplier bit per cycle; exact range check at the end.
          if (cnt == 5'd31) begin
            state <= S_FIN;
            if (mul_sum[32:1] != 32'd0 ||
                (mul_sum[0] && !(neg && prod[31:1] == 31'd0))) begin
              st   <= ST_OVF;
              stop <= 1'b1;
            end else if (neg) begin
              acc <= -$signed({mul_sum[0], prod[31:1]});
            end else begin
              acc <= $signed({mul_sum[0], prod[31:1]});
            end
          end
          prod <= {mul_sum, prod[31:1]};
          cnt  <= cnt + 5'd1;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (!div_t[32]) begin
            rem <= div_t[31:0];
          end else begin
            rem <= {rem[30:0], qr[31]};
          end
          qr  <= {qr[30:0], !div_t[32]};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_FIN;
            if (neg) begin
              acc <= -$signed({qr[30:0], !div_t[32]});
            end else begin
              acc <= $signed({qr[30:0], !div_t[32]});
            end
          end
        end
        S_FIN: begin
          if (stop) begin
            running <= 1'b0;
          end else if (nxt >= PC_END) begin
            pc      <= PC_END;
            running <= 1'b0;
            st      <= ST_END;
          end else begin
            pc <= nxt;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/decimal_accumulator_cpu.sv]
// A load, a rejected load or an ignored step goes from idle to done; an instruction runs
// fetch, decode, operand, execute and finish; multiply and divide go one bit per cycle.
// Throughput: one item at a time in the execution unit; a two-entry input queue and a
// one-entry result register let both sides stall on their own.
// Reset (rst, synchronous): queues empty, accumulator and counter zero, machine running,
// all memory words read as zero until written.
module decimal_accumulator_cpu
  import dacc_pkg::*;
#(
  parameter int MEM_WORDS = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               req_type,
  input  logic [ADDR_W-1:0]  load_address,
  input  logic signed [31:0] data_word,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic               printed,
  output logic signed [31:0] printed_value,
  output logic signed [31:0] fetched_word,
  output logic signed [31:0] acc_value,
  output logic [ADDR_W-1:0]  next_pc
);

  queue_out_t qout;
  logic       take;
  logic       res_valid;
  logic       res_ready;
  result_t    res;
  result_t    obuf;
  logic       obuf_valid;

  dacc_front #(
    .MEM_WORDS(MEM_WORDS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .load_address(load_address),
    .data_word   (data_word),
    .qout        (qout),
    .take        (take)
  );

  dacc_back #(
    .MEM_WORDS(MEM_WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .qin      (qout),
    .take     (take),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Result register: a new transfer can land as the old one is popped.
  assign res_ready = !obuf_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        obuf       <= res;
        obuf_valid <= 1'b1;
      end else if (pop) begin
        obuf_valid <= 1'b0;
      end
    end
  end

  assign empty         = !obuf_valid;
  assign status        = obuf.status;
  assign printed       = obuf.printed;
  assign printed_value = obuf.pval;
  assign fetched_word  = obuf.fetched;
  assign acc_value     = obuf.acc;
  assign next_pc       = obuf.pc;

  // A printed value only comes from an instruction that completed.
  a_printed_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && printed) |-> (status == ST_OK || status == ST_END))
    else $error("printed set with an error status");

  // Rejected loads and ignored steps fetch and print nothing.
  a_no_fetch: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == ST_REJ || status == ST_IGN)) |-> (fetched_word == 0 && !printed))
    else $error("ignored item shows fetch or print");

  // The counter never passes the end marker.
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (next_pc <= ADDR_W'(MEM_WORDS)))
    else $error("program counter out of range");

endmodule
